>>> hdl/srr_pkg.sv
// Shared types and constants for the selective-repeat ARQ receiver.
// Depends on nothing; imported by the controller, the datapath and the top level.

package srr_pkg;

    // Sequence space and window
    localparam int SEQ_SPACE = 8;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);
    localparam int WINDOW    = SEQ_SPACE / 2;
    localparam int CNT_W     = $clog2(WINDOW + 1);

    // Payload word and packed stream widths
    localparam int PAY_W   = 32;
    localparam int FIELD_W = SEQ_W + PAY_W;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    // Result kinds carried on m_tuser
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch an accepted good packet, store it if in window
        logic deliver;   // emit the slot at the base and advance the base
        logic ack;       // emit the ack for the latched packet
    } srr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic can_deliver;  // slot at the base is filled and the scan may go on
    } srr_status_t;

endpackage

>>> hdl/srr_ctrl.sv
// Sequencing state machine for the selective-repeat ARQ receiver.
// Depends on srr_pkg; drives commands into srr_datapath and reads its status.

module srr_ctrl
    import srr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        chk_ok,
    output logic        s_tready,
    input  srr_status_t status,
    output srr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Accept requests only while no packet is being worked on
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.deliver = 1'b0;
        cmd.ack     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // Drop bad packets; good ones go on to the delivery scan
                if (s_tvalid && chk_ok) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.out_free) begin
                    if (status.can_deliver) begin
                        cmd.deliver = 1'b1;
                    end else begin
                        cmd.ack    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/srr_datapath.sv
// Slot store, base pointer, scan counter and output register of the receiver.
// Depends on srr_pkg; commanded by srr_ctrl.

module srr_datapath
    import srr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TDATA_W-1:0] s_tdata,
    input  srr_cmd_t           cmd,
    output srr_status_t        status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic [SEQ_SPACE-1:0] slot_valid_reg;
    logic [PAY_W-1:0]     slot_payload_reg [SEQ_SPACE];
    logic [SEQ_W-1:0]     base_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic                 win_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [SEQ_W-1:0]     out_number_reg;
    logic [PAY_W-1:0]     out_data_reg;
    logic                 out_last_reg;

    logic [SEQ_W-1:0]     in_seq;
    logic [PAY_W-1:0]     in_payload;
    logic [SEQ_W-1:0]     in_offset;
    logic                 in_window;
    logic                 out_load;

    // Unpack the request and test it against the receive window
    assign in_seq     = s_tdata[SEQ_W-1:0];
    assign in_payload = s_tdata[FIELD_W-1:SEQ_W];
    assign in_offset  = in_seq - base_reg;
    assign in_window  = (in_offset < SEQ_W'(WINDOW));

    // Status for the controller
    assign status.out_free    = !out_valid_reg || m_tready;
    assign status.can_deliver = win_reg && (cnt_reg < CNT_W'(WINDOW))
                                && slot_valid_reg[base_reg];

    assign out_load = cmd.deliver || cmd.ack;

    // Slot valid bits, base pointer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.capture && in_window) begin
                slot_valid_reg[in_seq] <= 1'b1;
            end
            if (cmd.deliver) begin
                slot_valid_reg[base_reg] <= 1'b0;
                base_reg                 <= base_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload store, latched packet and scan counter
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            seq_reg <= in_seq;
            win_reg <= in_window;
            cnt_reg <= '0;
            if (in_window) begin
                slot_payload_reg[in_seq] <= in_payload;
            end
        end
        if (cmd.deliver) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Output register: a delivery or the closing ack
    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            out_kind_reg   <= KIND_DELIVER;
            out_number_reg <= base_reg;
            out_data_reg   <= slot_payload_reg[base_reg];
            out_last_reg   <= 1'b0;
        end else if (cmd.ack) begin
            out_kind_reg   <= KIND_ACK;
            out_number_reg <= seq_reg;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, out_data_reg, out_number_reg};

endmodule

>>> hdl/selective_repeat_receiver.sv
// Top level of the selective-repeat ARQ receiver.
// Depends on srr_pkg, srr_ctrl and srr_datapath.

// Selective-repeat ARQ receiver. Each request on the slave side is one packet:
// a sequence number, a checksum-good flag and a payload word. A good packet
// inside the window of SEQ_SPACE/2 sequence numbers from the base is stored in
// its slot; then the filled slots from the base are delivered in order
// (m_tuser low), and one ack with the packet's sequence number closes the
// packet's results (m_tuser high, m_tlast high). Bad packets produce nothing.
// A good packet is captured first; then the deliveries it releases (0 to
// SEQ_SPACE/2) and its ack leave through the single output register, which
// emits one result per cycle unless m_tready holds it. A new packet is taken
// as soon as its predecessor's ack is loaded into the output register, while
// that ack may still be waiting on m_tready.

module selective_repeat_receiver
    import srr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Packet requests
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [2:0] seq_num, [34:3] payload, rest zero
    input  logic               s_tuser,   // [0] checksum_ok
    // Results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [2:0] number, [34:3] data, rest zero
    output logic               m_tuser,   // [0] kind: 0 delivery, 1 ack
    output logic               m_tlast    // high on the ack that ends a packet
);

    srr_cmd_t    cmd;
    srr_status_t status;

    srr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .chk_ok   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
